### design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Transaction types, calibration slot numbers and the fixed coefficients of
// the integer compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int NumSlots = 11;

  localparam logic [3:0] SlotAc1 = 4'd0;
  localparam logic [3:0] SlotAc2 = 4'd1;
  localparam logic [3:0] SlotAc3 = 4'd2;
  localparam logic [3:0] SlotAc4 = 4'd3;
  localparam logic [3:0] SlotAc5 = 4'd4;
  localparam logic [3:0] SlotAc6 = 4'd5;
  localparam logic [3:0] SlotB1  = 4'd6;
  localparam logic [3:0] SlotB2  = 4'd7;
  localparam logic [3:0] SlotMc  = 4'd9;
  localparam logic [3:0] SlotMd  = 4'd10;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpConvert = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusDivZero = 1'b1;

  localparam logic signed [31:0] B6Offset = 32'sd4000;
  localparam logic signed [31:0] B4Bias   = 32'sd32768;
  localparam logic signed [31:0] PSqCoef  = 32'sd3038;
  localparam logic signed [31:0] PLinCoef = -32'sd7357;
  localparam logic signed [31:0] POffset  = 32'sd3791;
  localparam logic signed [31:0] B7Scale  = 32'sd50000 / 32'sd4;
  localparam logic signed [31:0] TempMax  = 32'sd32767;
  localparam logic signed [31:0] TempMin  = -32'sd32768;
  localparam logic signed [31:0] PresMax  = 32'sd131071;

  typedef struct packed {
    logic        op;
    logic [3:0]  coeff_index;
    logic [15:0] coeff_word;
    logic [15:0] raw_temperature;
    logic [17:0] raw_pressure;
  } req_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [16:0]        pressure_pa;
    logic               status;
  } rsp_t;

endpackage

### design/bsc_if.sv
// ----------------------------------------------------------------------------
// Barometric compensation channels
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface bsc_req_if;
  logic          valid;
  logic          ready;
  bsc_pkg::req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface bsc_rsp_if;
  logic          valid;
  logic          ready;
  bsc_pkg::rsp_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### design/barometric_sensor_compensation_core.sv
// Load transaction: the core is ready again in the next cycle.
// Convert transaction: two passes of the shared radix-2 divider run in the sequence,
// and the core takes no new request until the result is in the response register.
// A zero divisor ends the conversion early with an error status.
// Reset clears the calibration store, the sequencer and the response valid flag.
// ----------------------------------------------------------------------------
// Barometric compensation core
// Calibration store and a sequencer around one shared 32x32 multiplier and
// one shared bit-serial divider that compensate temperature and pressure.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core (
  input logic       clk,
  input logic       rst,
  bsc_req_if.sink   req,
  bsc_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_TDIV, S_T3, S_T4,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
    S_PDIV, S_P11, S_P12, S_P13, S_P14, S_P15, S_DONE
  } state_t;

  state_t state;

  logic [15:0] coeff [bsc_pkg::NumSlots];

  logic [15:0] ut;
  logic [17:0] pu;
  logic        err;
  logic        b7_msb;

  logic        [31:0] prod;
  logic signed [31:0] x1, x3, b5, b6, sq, b3, t, p;
  logic        [31:0] b4;

  logic [31:0] dv_rem, dv_quo, dv_den;
  logic [4:0]  dv_cnt;
  logic        dv_neg;

  logic        rsp_valid;
  bsc_pkg::rsp_t rsp_data;

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [31:0] ac4, ac5, ac6;

  logic [31:0] mul_a, mul_b;

  logic signed [31:0] prod_s;
  logic signed [31:0] tdiv, tnum, quo_s, b3_raw, p_corr;
  logic [32:0] dv_shift, dv_trial;

  assign ac1 = {{16{coeff[bsc_pkg::SlotAc1][15]}}, coeff[bsc_pkg::SlotAc1]};
  assign ac2 = {{16{coeff[bsc_pkg::SlotAc2][15]}}, coeff[bsc_pkg::SlotAc2]};
  assign ac3 = {{16{coeff[bsc_pkg::SlotAc3][15]}}, coeff[bsc_pkg::SlotAc3]};
  assign ac4 = {16'b0, coeff[bsc_pkg::SlotAc4]};
  assign ac5 = {16'b0, coeff[bsc_pkg::SlotAc5]};
  assign ac6 = {16'b0, coeff[bsc_pkg::SlotAc6]};
  assign b1  = {{16{coeff[bsc_pkg::SlotB1][15]}}, coeff[bsc_pkg::SlotB1]};
  assign b2  = {{16{coeff[bsc_pkg::SlotB2][15]}}, coeff[bsc_pkg::SlotB2]};
  assign mc  = {{16{coeff[bsc_pkg::SlotMc][15]}}, coeff[bsc_pkg::SlotMc]};
  assign md  = {{16{coeff[bsc_pkg::SlotMd][15]}}, coeff[bsc_pkg::SlotMd]};

  assign prod_s = $signed(prod);
  assign tdiv   = (prod_s >>> 15) + md;
  assign tnum   = mc <<< 11;
  assign quo_s  = dv_neg ? -$signed(dv_quo) : $signed(dv_quo);
  assign b3_raw = (((ac1 <<< 2) + x3) <<< 2) + 32'sd2;
  assign p_corr = (x1 + (prod_s >>> 16) + bsc_pkg::POffset) >>> 4;

  assign dv_shift = {dv_rem, dv_quo[31]};
  assign dv_trial = dv_shift - {1'b0, dv_den};

  always_comb begin
    unique case (state)
      S_T1: begin
        mul_a = {16'b0, ut} - ac6;
        mul_b = ac5;
      end
      S_P1: begin
        mul_a = b6;
        mul_b = b6;
      end
      S_P3: begin
        mul_a = b2;
        mul_b = sq;
      end
      S_P4: begin
        mul_a = ac2;
        mul_b = b6;
      end
      S_P5: begin
        mul_a = ac3;
        mul_b = b6;
      end
      S_P6: begin
        mul_a = b1;
        mul_b = sq;
      end
      S_P8: begin
        mul_a = ac4;
        mul_b = x3 + bsc_pkg::B4Bias;
      end
      S_P9: begin
        mul_a = {14'b0, pu} - b3;
        mul_b = bsc_pkg::B7Scale;
      end
      S_P12: begin
        mul_a = p >>> 8;
        mul_b = p >>> 8;
      end
      S_P13: begin
        mul_a = prod;
        mul_b = bsc_pkg::PSqCoef;
      end
      S_P14: begin
        mul_a = bsc_pkg::PLinCoef;
        mul_b = p;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      err       <= 1'b0;
      dv_cnt    <= '0;
      for (int i = 0; i < bsc_pkg::NumSlots; i++) begin
        coeff[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.payload.op == bsc_pkg::OpLoad) begin
              if (req.payload.coeff_index < 4'(bsc_pkg::NumSlots)) begin
                coeff[req.payload.coeff_index] <= req.payload.coeff_word;
              end
            end else begin
              ut    <= req.payload.raw_temperature;
              pu    <= req.payload.raw_pressure;
              err   <= 1'b0;
              state <= S_T1;
            end
          end
        end
        S_T1: state <= S_T2;
        S_T2: begin
          x1 <= prod_s >>> 15;
          if (tdiv == 32'sd0) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            dv_rem <= '0;
            dv_quo <= tnum[31] ? -tnum : tnum;
            dv_den <= tdiv[31] ? -tdiv : tdiv;
            dv_neg <= tnum[31] ^ tdiv[31];
            dv_cnt <= '0;
            state  <= S_TDIV;
          end
        end
        S_TDIV, S_PDIV: begin
          if (!dv_trial[32]) begin
            dv_rem <= dv_trial[31:0];
            dv_quo <= {dv_quo[30:0], 1'b1};
          end else begin
            dv_rem <= dv_shift[31:0];
            dv_quo <= {dv_quo[30:0], 1'b0};
          end
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'd31) begin
            state <= (state == S_TDIV) ? S_T3 : S_P11;
          end
        end
        S_T3: begin
          b5    <= x1 + quo_s;
          state <= S_T4;
        end
        S_T4: begin
          t     <= (b5 + 32'sd8) >>> 4;
          b6    <= b5 - bsc_pkg::B6Offset;
          state <= S_P1;
        end
        S_P1: state <= S_P2;
        S_P2: begin
          sq    <= prod_s >>> 12;
          state <= S_P3;
        end
        S_P3: state <= S_P4;
        S_P4: begin
          x1    <= prod_s >>> 11;
          state <= S_P5;
        end
        S_P5: begin
          x3    <= x1 + (prod_s >>> 11);
          state <= S_P6;
        end
        S_P6: begin
          b3    <= (b3_raw + (b3_raw[31] ? 32'sd3 : 32'sd0)) >>> 2;
          x1    <= prod_s >>> 13;
          state <= S_P7;
        end
        S_P7: begin
          x3    <= (x1 + (prod_s >>> 16) + 32'sd2) >>> 2;
          state <= S_P8;
        end
        S_P8: state <= S_P9;
        S_P9: begin
          b4    <= prod >> 15;
          state <= S_P10;
        end
        S_P10: begin
          if (b4 == 32'd0) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            dv_rem <= '0;
            dv_quo <= prod[31] ? prod : (prod << 1);
            dv_den <= b4;
            dv_neg <= 1'b0;
            dv_cnt <= '0;
            b7_msb <= prod[31];
            state  <= S_PDIV;
          end
        end
        S_P11: begin
          p     <= b7_msb ? (dv_quo << 1) : dv_quo;
          state <= S_P12;
        end
        S_P12: state <= S_P13;
        S_P13: state <= S_P14;
        S_P14: begin
          x1    <= prod_s >>> 16;
          state <= S_P15;
        end
        S_P15: begin
          p     <= p + p_corr;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            if (err) begin
              rsp_data.temperature_tenths <= '0;
              rsp_data.pressure_pa        <= '0;
              rsp_data.status             <= bsc_pkg::StatusDivZero;
            end else begin
              if (t > bsc_pkg::TempMax) begin
                rsp_data.temperature_tenths <= 16'sh7fff;
              end else if (t < bsc_pkg::TempMin) begin
                rsp_data.temperature_tenths <= 16'sh8000;
              end else begin
                rsp_data.temperature_tenths <= t[15:0];
              end
              if (p < 32'sd0) begin
                rsp_data.pressure_pa <= '0;
              end else if (p > bsc_pkg::PresMax) begin
                rsp_data.pressure_pa <= bsc_pkg::PresMax[16:0];
              end else begin
                rsp_data.pressure_pa <= p[16:0];
              end
              rsp_data.status <= bsc_pkg::StatusOk;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.status == bsc_pkg::StatusDivZero
    |-> rsp.payload.temperature_tenths == 16'sd0 && rsp.payload.pressure_pa == 17'd0)
    else $error("error response carries nonzero fields");

  a_div_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !(state == S_TDIV || state == S_PDIV) |-> dv_cnt == 5'd0)
    else $error("divider count left running");

  a_convert_start: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.payload.op == bsc_pkg::OpConvert |=> state == S_T1)
    else $error("convert transaction did not start the sequencer");

  a_no_rsp_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !rsp.valid |=> !rsp.valid)
    else $error("response raised without a conversion");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && rsp.valid && !rsp.ready |=> state == S_DONE)
    else $error("finished result dropped while response stalled");

endmodule

### tb/sv/bsc_compensation_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Watches the request and response channels and keeps its own copy of the
// calibration store. Each accepted convert transaction is turned into the
// expected temperature, pressure and status with the 32-bit integer
// compensation. Each accepted response is compared field by field with the
// oldest expected reading. The failure count and the number of readings
// still owed go to the testbench top.
// ----------------------------------------------------------------------------
module bsc_compensation_checker (
  input  logic clk,
  input  logic rst,
  bsc_req_if   req,
  bsc_rsp_if   rsp,
  output int   fails,
  output int   pending
);

  typedef logic signed [31:0] s32_t;

  logic [15:0]   cal [bsc_pkg::NumSlots];
  bsc_pkg::rsp_t expected_readings [$];
  bsc_pkg::rsp_t got;
  bsc_pkg::rsp_t want;

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fails = fails + 1;
  endtask

  function automatic s32_t sext(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // Truncating division; the minimum value over minus one wraps to itself.
  function automatic s32_t quot(input s32_t a, input s32_t b);
    if (a == {1'b1, 31'd0} && b == -32'sd1) return a;
    return a / b;
  endfunction

  function automatic bsc_pkg::rsp_t compensate(input bsc_pkg::req_t item);
    s32_t          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    s32_t          ut, x1, x2, x3, b5, b6, b3, t, p, sq, divisor;
    logic [31:0]   ac4, pu, b4, b7, prod;
    bsc_pkg::rsp_t r;
    r.temperature_tenths = '0;
    r.pressure_pa = '0;
    r.status = bsc_pkg::StatusDivZero;
    ac1 = sext(cal[bsc_pkg::SlotAc1]);
    ac2 = sext(cal[bsc_pkg::SlotAc2]);
    ac3 = sext(cal[bsc_pkg::SlotAc3]);
    ac4 = {16'd0, cal[bsc_pkg::SlotAc4]};
    ac5 = {16'd0, cal[bsc_pkg::SlotAc5]};
    ac6 = {16'd0, cal[bsc_pkg::SlotAc6]};
    b1  = sext(cal[bsc_pkg::SlotB1]);
    b2  = sext(cal[bsc_pkg::SlotB2]);
    mc  = sext(cal[bsc_pkg::SlotMc]);
    md  = sext(cal[bsc_pkg::SlotMd]);
    ut  = {16'd0, item.raw_temperature};
    pu  = {14'd0, item.raw_pressure};

    x1 = ((ut - ac6) * ac5) >>> 15;
    divisor = x1 + md;
    if (divisor == 0) return r;
    x2 = quot(mc * 32'sd2048, divisor);
    b5 = x1 + x2;
    t  = (b5 + 32'sd8) >>> 4;

    b6 = b5 - bsc_pkg::B6Offset;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = quot(((ac1 * 32'sd4 + x3) * 32'sd4) + 32'sd2, 32'sd4);
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 32'sd2) >>> 2;
    prod = ac4 * $unsigned(x3 + bsc_pkg::B4Bias);
    b4 = prod >> 15;
    if (b4 == 0) return r;
    b7 = (pu - $unsigned(b3)) * $unsigned(bsc_pkg::B7Scale);
    if (b7 < 32'h8000_0000) begin
      prod = b7 << 1;
      p = prod / b4;
    end else begin
      prod = b7 / b4;
      p = prod << 1;
    end
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * bsc_pkg::PSqCoef) >>> 16;
    x2 = (bsc_pkg::PLinCoef * p) >>> 16;
    p  = p + ((x1 + x2 + bsc_pkg::POffset) >>> 4);

    if (t > bsc_pkg::TempMax) t = bsc_pkg::TempMax;
    if (t < bsc_pkg::TempMin) t = bsc_pkg::TempMin;
    if (p < 0) p = 0;
    if (p > bsc_pkg::PresMax) p = bsc_pkg::PresMax;

    r.temperature_tenths = t[15:0];
    r.pressure_pa = p[16:0];
    r.status = bsc_pkg::StatusOk;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (cal[i]) cal[i] = '0;
      expected_readings.delete();
      fails = 0;
      pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected result t=%0d p=%0d status=%0d",
                                  got.temperature_tenths, got.pressure_pa, got.status));
        end else begin
          want = expected_readings.pop_front();
          if (got.temperature_tenths !== want.temperature_tenths)
            note_mismatch($sformatf("temperature_tenths got %0d expected %0d",
                                    got.temperature_tenths, want.temperature_tenths));
          if (got.pressure_pa !== want.pressure_pa)
            note_mismatch($sformatf("pressure_pa got %0d expected %0d",
                                    got.pressure_pa, want.pressure_pa));
          if (got.status !== want.status)
            note_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
        end
      end
      if (req.valid && req.ready) begin
        if (req.payload.op == bsc_pkg::OpLoad) begin
          if (req.payload.coeff_index < bsc_pkg::NumSlots)
            cal[req.payload.coeff_index] = req.payload.coeff_word;
        end else begin
          expected_readings.push_back(compensate(req.payload));
        end
      end
      pending <= expected_readings.size();
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Loads calibration words and sends raw readings to the compensation core:
// a directed opening with the datasheet calibration, zero divisors, field
// extremes and saturation, then random calibration sets and readings with
// random idle bursts on both channels, a long response hold-off and a full
// drain. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int          ItemTarget = 1650;
  localparam int          QuietLimit = 3000;
  localparam int          HoldCycles = 400;
  localparam logic [3:0]  SlotNone   = 4'd15;
  localparam logic [15:0] DatasheetCal [bsc_pkg::NumSlots] = '{
    16'h0198, 16'hFFB8, 16'hC7D1, 16'h7FE5, 16'h7FF5, 16'h5A71,
    16'h182E, 16'h0004, 16'h8000, 16'hDDF9, 16'h0B34
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  bsc_pkg::req_t req_item = '0;
  logic          rsp_ready = 1'b0;
  logic          idle_on = 1'b1;
  int            hold_asks = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;
  int            item_count = 0;
  int            fails;
  int            pending;

  bsc_req_if req_ch ();
  bsc_rsp_if rsp_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.payload = req_item;
  assign rsp_ch.ready   = rsp_ready;

  barometric_sensor_compensation_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bsc_compensation_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_asks != hold_served) begin
        hold_left = HoldCycles;
        hold_served = hold_served + 1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input bsc_pkg::req_t item);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (item.op == bsc_pkg::OpConvert || item.coeff_index < bsc_pkg::NumSlots) item_count++;
  endtask

  task automatic load_word(input logic [3:0] idx, input logic [15:0] w);
    bsc_pkg::req_t it;
    it.op = bsc_pkg::OpLoad;
    it.coeff_index = idx;
    it.coeff_word = w;
    it.raw_temperature = 16'($urandom_range(0, 65535));
    it.raw_pressure = 18'($urandom_range(0, 262143));
    offer(it);
  endtask

  task automatic convert(input logic [15:0] ut, input logic [17:0] up);
    bsc_pkg::req_t it;
    it.op = bsc_pkg::OpConvert;
    it.coeff_index = 4'($urandom_range(0, 15));
    it.coeff_word = 16'($urandom_range(0, 65535));
    it.raw_temperature = ut;
    it.raw_pressure = up;
    offer(it);
  endtask

  task automatic load_calibration_set();
    int          mode;
    logic [15:0] w;
    mode = $urandom_range(0, 5);
    for (int s = 0; s < bsc_pkg::NumSlots; s++) begin
      if (mode == 0) w = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 31) == 0) w = '0;
      else w = DatasheetCal[s] + 16'($urandom_range(0, 1023)) - 16'd512;
      load_word(4'(s), w);
    end
  endtask

  initial begin
    logic        held;
    logic        drained;
    int          choice;
    logic [15:0] ut;
    logic [17:0] up;
    held = 1'b0;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    convert(16'd27898, 18'd95372);
    for (int s = 0; s < bsc_pkg::NumSlots; s++) load_word(4'(s), DatasheetCal[s]);
    convert(16'd27898, 18'd95372);
    load_word(SlotNone, 16'hFFFF);
    convert(16'h0000, 18'h00000);
    convert(16'hFFFF, 18'h3FFFF);
    load_word(bsc_pkg::SlotAc4, 16'h0000);
    convert(16'd27898, 18'd95372);
    load_word(bsc_pkg::SlotAc4, DatasheetCal[bsc_pkg::SlotAc4]);
    load_word(bsc_pkg::SlotAc5, 16'h0000);
    load_word(bsc_pkg::SlotMd, 16'h0001);
    load_word(bsc_pkg::SlotMc, 16'h7FFF);
    convert(16'd27898, 18'd95372);
    load_word(bsc_pkg::SlotMc, 16'h8000);
    convert(16'd27898, 18'd95372);

    while (item_count < ItemTarget) begin
      idle_on <= (item_count < 1400) && ((item_count / 120) % 3 != 2);
      if (!held && item_count >= 500) begin
        hold_asks <= hold_asks + 1;
        held = 1'b1;
      end
      if (!drained && item_count >= 1000) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        drained = 1'b1;
      end
      choice = $urandom_range(0, 15);
      if (choice < 3) begin
        load_calibration_set();
      end else if (choice < 4) begin
        load_word(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) ut = 16'($urandom_range(20000, 40000));
          else ut = 16'($urandom_range(0, 65535));
          if ($urandom_range(0, 1) == 0) up = 18'($urandom_range(60000, 140000));
          else up = 18'($urandom_range(0, 262143));
          convert(ut, up);
        end
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
